// ===== design/dre_pkg.sv =====
`default_nettype none
package dre_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_ELECT = 1'b1;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS          = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_PRIORITY         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_PRIORITY_PRESENT = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  slot;
      logic        entry_valid;
      logic [31:0] entry_address;
      logic        entry_priority_present;
      logic [31:0] entry_priority;
      logic        exclude_enable;
      logic [31:0] exclude_address;
   } req_type;

   typedef struct packed {
      logic [31:0] dr_address;
      logic        i_am_dr;
      logic        may_become_dr;
   } rsp_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] prio;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== design/dre_ctrl.sv =====
`default_nettype none
module dre_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_cmd,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output dre_pkg::dp_cmd_type    dp_cmd,
   input  dre_pkg::dp_status_type dp_status
);
   import dre_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      dp_cmd.accept = 1'b0;
      dp_cmd.issue  = 1'b0;
      dp_cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_cmd.accept = 1'b1;
               state_in = (req_cmd == CMD_ELECT) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            dp_cmd.issue = 1'b1;
            if (dp_status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               dp_cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = dp_cmd.finish ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(state_ff == ST_SCAN))
      else $error("drain not preceded by scan");

   a_write_skips_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_WRITE) |=> (state_ff == ST_FINISH))
      else $error("write item entered scan");

endmodule
`default_nettype wire

// ===== design/dre_datapath.sv =====
`default_nettype none
module dre_datapath #(
   parameter int NEIGHBOR_SLOTS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_enable,
   input  wire  [dre_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [31:0]                           csr_write_data,
   input  dre_pkg::req_type                      req_data,
   input  dre_pkg::dp_cmd_type                   dp_cmd,
   output dre_pkg::dp_status_type                dp_status,
   output dre_pkg::rsp_type                      rsp_data
);
   import dre_pkg::*;

   localparam int IDX_W   = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NEIGHBOR_SLOTS + 1);
   localparam int SLOT_XW = (IDX_W > 4) ? IDX_W : 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEIGHBOR_SLOTS - 1);

   // configuration
   logic [31:0] own_address_ff;
   logic [31:0] own_priority_ff;
   logic        own_present_ff;

   // neighbor table
   logic                slot_valid_ff  [NEIGHBOR_SLOTS];
   logic                slot_noprio_ff [NEIGHBOR_SLOTS];
   entry_type           slot_mem_ff    [NEIGHBOR_SLOTS];
   logic [CNT_W-1:0]    nopri_cnt_ff, nopri_cnt_in;

   // election
   req_type             req_ff;
   logic                use_prio_ff;
   logic [IDX_W-1:0]    cnt_ff;
   logic                rd_pend_ff;
   logic                rd_valid_ff;
   entry_type           rd_entry_ff;
   logic [31:0]         best_addr_ff, best_addr_in;
   logic [31:0]         best_prio_ff, best_prio_in;
   logic [31:0]         elected_ff, elected_in;
   logic                am_dr_ff, am_dr_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SLOT_XW-1:0]  slot_ext;
   logic [IDX_W-1:0]    wr_idx;
   logic                wr_en;
   logic                old_bad, new_bad;
   logic                best_wins, skip, take;
   logic                commit, query;

   assign slot_ext = SLOT_XW'(req_data.slot);
   assign wr_idx   = slot_ext[IDX_W-1:0];
   assign wr_en    = dp_cmd.accept && (req_data.cmd == CMD_WRITE)
                     && (9'(req_data.slot) < 9'(NEIGHBOR_SLOTS));
   assign old_bad  = slot_valid_ff[wr_idx] && slot_noprio_ff[wr_idx];
   assign new_bad  = req_data.entry_valid && !req_data.entry_priority_present;

   always_comb begin
      nopri_cnt_in = nopri_cnt_ff;
      if (wr_en) begin
         nopri_cnt_in = nopri_cnt_ff + CNT_W'(new_bad) - CNT_W'(old_bad);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff  <= '0;
         own_priority_ff <= 32'd1;
         own_present_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:          own_address_ff  <= csr_write_data;
            CSR_OWN_PRIORITY:         own_priority_ff <= csr_write_data;
            CSR_OWN_PRIORITY_PRESENT: own_present_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NEIGHBOR_SLOTS; k++) begin
            slot_valid_ff[k] <= 1'b0;
         end
         nopri_cnt_ff <= '0;
      end else begin
         if (wr_en) begin
            slot_valid_ff[wr_idx] <= req_data.entry_valid;
         end
         nopri_cnt_ff <= nopri_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && req_data.entry_valid) begin
         slot_noprio_ff[wr_idx] <= !req_data.entry_priority_present;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && req_data.entry_valid) begin
         slot_mem_ff[wr_idx] <= '{address: req_data.entry_address,
                                  prio:    req_data.entry_priority};
      end
      rd_entry_ff <= slot_mem_ff[cnt_ff];
      rd_valid_ff <= slot_valid_ff[cnt_ff];
   end

   assign best_wins = (use_prio_ff && (best_prio_ff != rd_entry_ff.prio))
                      ? (best_prio_ff > rd_entry_ff.prio)
                      : (best_addr_ff > rd_entry_ff.address);
   assign skip = req_ff.exclude_enable && (rd_entry_ff.address == req_ff.exclude_address);
   assign take = rd_pend_ff && rd_valid_ff && !skip && !best_wins;

   always_comb begin
      best_addr_in = best_addr_ff;
      best_prio_in = best_prio_ff;
      if (dp_cmd.accept) begin
         best_addr_in = own_address_ff;
         best_prio_in = own_priority_ff;
      end else if (take) begin
         best_addr_in = rd_entry_ff.address;
         best_prio_in = rd_entry_ff.prio;
      end
   end

   assign commit = (req_ff.cmd == CMD_ELECT) && !req_ff.exclude_enable;
   assign query  = (req_ff.cmd == CMD_ELECT) && req_ff.exclude_enable;

   always_comb begin
      elected_in = elected_ff;
      am_dr_in   = am_dr_ff;
      if (dp_cmd.finish && commit) begin
         elected_in = best_addr_ff;
         am_dr_in   = (best_addr_ff == own_address_ff);
      end
      rsp_in.dr_address    = elected_in;
      rsp_in.i_am_dr       = am_dr_in;
      rsp_in.may_become_dr = query && (best_addr_ff == own_address_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
         elected_ff <= '0;
         am_dr_ff   <= 1'b0;
      end else begin
         if (dp_cmd.accept) begin
            cnt_ff <= '0;
         end else if (dp_cmd.issue) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
         end
         rd_pend_ff <= dp_cmd.issue;
         elected_ff <= elected_in;
         am_dr_ff   <= am_dr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         req_ff      <= req_data;
         use_prio_ff <= own_present_ff && (nopri_cnt_ff == '0);
      end
      best_addr_ff <= best_addr_in;
      best_prio_ff <= best_prio_in;
      if (dp_cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign dp_status.scan_last = (cnt_ff == LAST_IDX);
   assign rsp_data            = rsp_ff;

   a_nopri_bound: assert property (@(posedge clock) disable iff (reset)
      nopri_cnt_ff <= CNT_W'(NEIGHBOR_SLOTS))
      else $error("missing-priority count out of range");

endmodule
`default_nettype wire

// ===== design/designated_router_election.sv =====
`default_nettype none
// Channel   Ports                                         Direction
// request   req_valid, req_stall, req_data                in  (req_stall out)
// response  rsp_valid, rsp_stall, rsp_data                out (rsp_stall in)
// config    csr_write_enable, csr_index, csr_write_data   in
//
// Write item: accept, then finish. Elect item: accept, a scan of every slot in turn,
// a drain of the registered read, then finish; the scan pace is set by the
// single read port of the slot memory (one entry a cycle).
// One item at a time; the next is accepted once a result sits in the output register.
// A stalled result holds in that register; only the finish of the next item waits on it.
// Synchronous reset clears valid bits and stored DR and loads default config; no clearing pass.
module designated_router_election #(
   parameter int NEIGHBOR_SLOTS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_write_enable,
   input  wire  [dre_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [31:0]                      csr_write_data,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  dre_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output dre_pkg::rsp_type                 rsp_data
);
   import dre_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   dre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   dre_datapath #(
      .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .rsp_data         (rsp_data)
   );

endmodule
`default_nettype wire
